>>> rtl/core/utf8_to_utf16_transcoder_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder assertion macros
// Shared assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define U8U16_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define U8U16_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define U8U16_ASSERT(lbl, prop, msg)
`define U8U16_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/core/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Transaction types, the queue descriptor and the decoding constants.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_end;
    logic        string_end;
  } out_item_t;

  // One decoded input byte: a run of replacement units followed by up to
  // two ordinary code units.
  typedef struct packed {
    logic [2:0]  rep_cnt;
    logic [1:0]  tail_cnt;
    logic [15:0] tail_hi;
    logic [15:0] tail_lo;
    logic        final_byte;
  } desc_t;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] REPLACEMENT    = 16'hFFFD;
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam logic [20:0] SUPP_BASE      = 21'h10000;

  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] CONT_A0    = 8'hA0;
  localparam logic [7:0] CONT_90    = 8'h90;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

endpackage

>>> rtl/core/u8u16_front.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder front end
// Accepts bytes, tracks the pending sequence and writes one descriptor per
// byte that yields code units.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_defines.svh"

module u8u16_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  u8u16_pkg::in_item_t  in_item,
  input  logic                 q_full,
  output logic                 q_push,
  output u8u16_pkg::desc_t     q_desc
);
  import u8u16_pkg::*;

  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] len;
    len = LEN_NONE;
    if (lead >= LEAD2_MIN && lead <= LEAD2_MAX) len = LEN_2;
    if (lead >= LEAD3_MIN && lead <= LEAD3_MAX) len = LEN_3;
    if (lead >= LEAD4_MIN && lead <= LEAD4_MAX) len = LEN_4;
    return len;
  endfunction

  logic        in_seq_r, in_seq_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic [1:0]  conts_r, conts_nxt;
  logic [20:0] point_r, point_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        fin;
  logic [2:0]  cur_len;
  logic [2:0]  byte_len;
  logic        cont_ok;
  logic [2:0]  conts_inc;
  logic [20:0] point_acc;
  logic [20:0] surr_v;
  logic        start_needed;
  desc_t       desc;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign b      = in_item.data_byte;
  assign fin    = in_item.final_byte;

  always_comb begin
    in_seq_nxt   = in_seq_r;
    lead_nxt     = lead_r;
    conts_nxt    = conts_r;
    point_nxt    = point_r;
    desc         = '0;
    desc.final_byte = fin;
    start_needed = 1'b0;
    cur_len      = seq_len(lead_r);
    byte_len     = seq_len(b);
    conts_inc    = {1'b0, conts_r} + 3'd1;
    point_acc    = {point_r[14:0], b[5:0]};
    surr_v       = point_acc - SUPP_BASE;

    cont_ok = (b[7:6] == 2'b10);
    if (conts_r == 2'd0) begin
      if (lead_r == LEAD_E0 && b < CONT_A0) cont_ok = 1'b0;
      if (lead_r == LEAD_ED && b >= CONT_A0) cont_ok = 1'b0;
      if (lead_r == LEAD_F0 && b < CONT_90) cont_ok = 1'b0;
      if (lead_r == LEAD_F4 && b >= CONT_90) cont_ok = 1'b0;
    end

    if (in_seq_r) begin
      if (cont_ok) begin
        if (conts_inc == cur_len - 3'd1) begin
          if (cur_len == LEN_4) begin
            desc.tail_cnt = 2'd2;
            desc.tail_hi  = HIGH_SURR_BASE + {6'd0, surr_v[19:10]};
            desc.tail_lo  = LOW_SURR_BASE + {6'd0, surr_v[9:0]};
          end else begin
            desc.tail_cnt = 2'd1;
            desc.tail_hi  = point_acc[15:0];
          end
          in_seq_nxt = 1'b0;
          lead_nxt   = '0;
          conts_nxt  = '0;
          point_nxt  = '0;
        end else if (fin) begin
          desc.rep_cnt = conts_inc + 3'd1;
        end else begin
          conts_nxt = conts_inc[1:0];
          point_nxt = point_acc;
        end
      end else begin
        desc.rep_cnt = {1'b0, conts_r} + 3'd1;
        in_seq_nxt   = 1'b0;
        lead_nxt     = '0;
        conts_nxt    = '0;
        point_nxt    = '0;
        start_needed = 1'b1;
      end
    end else begin
      start_needed = 1'b1;
    end

    if (start_needed) begin
      if (!b[7]) begin
        desc.tail_cnt = 2'd1;
        desc.tail_hi  = {8'h00, b};
      end else if (byte_len == LEN_NONE || fin) begin
        desc.rep_cnt = desc.rep_cnt + 3'd1;
      end else begin
        in_seq_nxt = 1'b1;
        lead_nxt   = b;
        conts_nxt  = '0;
        case (byte_len)
          LEN_2:   point_nxt = {16'd0, b[4:0]};
          LEN_3:   point_nxt = {17'd0, b[3:0]};
          default: point_nxt = {18'd0, b[2:0]};
        endcase
      end
    end

    if (fin) begin
      in_seq_nxt = 1'b0;
      lead_nxt   = '0;
      conts_nxt  = '0;
      point_nxt  = '0;
    end
  end

  assign q_desc = desc;
  assign q_push = accept && (desc.rep_cnt != 3'd0 || desc.tail_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_seq_r <= 1'b0;
      lead_r   <= '0;
      conts_r  <= '0;
      point_r  <= '0;
    end else if (accept) begin
      in_seq_r <= in_seq_nxt;
      lead_r   <= lead_nxt;
      conts_r  <= conts_nxt;
      point_r  <= point_nxt;
    end
  end

  `U8U16_ASSERT(a_final_clears, accept && fin |=> !in_seq_r && conts_r == 2'd0, "sequence state survives the final byte")
  `U8U16_NEVER(a_desc_bound, q_push && ({1'b0, q_desc.rep_cnt} + {2'b0, q_desc.tail_cnt} > 4'd4), "descriptor holds more than four units")

endmodule

>>> rtl/core/u8u16_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder descriptor queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_defines.svh"

module u8u16_queue #(
  parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  u8u16_pkg::desc_t  wr_desc,
  output logic              q_full,
  input  logic              rd_en,
  output u8u16_pkg::desc_t  rd_desc,
  output logic              q_empty
);
  import u8u16_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_desc = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

  `U8U16_NEVER(a_push_when_full, wr_en && q_full, "descriptor pushed into a full queue")

endmodule

>>> rtl/core/u8u16_back.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder back end
// Expands each descriptor into code units and loads them into the output
// register, one per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_defines.svh"

module u8u16_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u8u16_pkg::desc_t     head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output u8u16_pkg::out_item_t out_item
);
  import u8u16_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] n_units;
  logic [2:0] idx_ext;
  logic [2:0] tail_idx;
  logic       last;
  logic       load;
  out_item_t  unit;

  assign n_units  = head.rep_cnt + {1'b0, head.tail_cnt};
  assign idx_ext  = {1'b0, idx_r};
  assign tail_idx = idx_ext - head.rep_cnt;
  assign last     = (idx_ext + 3'd1 == n_units);
  assign load     = !q_empty && (!out_valid_r || pop);
  assign q_pop    = load && last;

  always_comb begin
    if (idx_ext < head.rep_cnt) begin
      unit.code_unit = REPLACEMENT;
    end else if (tail_idx[0]) begin
      unit.code_unit = head.tail_lo;
    end else begin
      unit.code_unit = head.tail_hi;
    end
    unit.run_end    = last;
    unit.string_end = last && head.final_byte;
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= unit;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

  `U8U16_ASSERT(a_idx_in_range, !q_empty |-> idx_ext < n_units, "unit index runs past its descriptor")

endmodule

>>> rtl/core/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Strict UTF-8 decoder producing UTF-16 code units with U+FFFD substitution.
// ----------------------------------------------------------------------------
// Input channel: one byte per transaction on in_item, taken when push is
// high and full is low; final_byte marks the last byte of a string.
// Output channel: one UTF-16 code unit per transaction on out_item, shown
// while empty is low and taken when pop is high. run_end marks the last unit
// caused by a byte and string_end the last unit of the string.
// A byte that yields code units is written to the descriptor queue at the
// edge that accepts it. Bytes are taken one per cycle while full is low.
// The back end emits one code unit per cycle while the output register is
// empty or popped, so a byte that yields n units (up to four) holds the back
// end until all are out; the queue absorbs such runs until it fills, and
// then full rises. A stalled receiver holds the output register, the queue
// fills behind it and full stops the input. Reset clears the sequence state,
// the queue and the output valid flag; no result is pending afterwards.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
  parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  u8u16_pkg::in_item_t  in_item,
  output logic                 empty,
  input  logic                 pop,
  output u8u16_pkg::out_item_t out_item
);
  import u8u16_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  desc_t q_wr_desc;
  desc_t q_head;

  u8u16_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_desc  (q_wr_desc)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_desc (q_wr_desc),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_desc (q_head),
    .q_empty (q_empty)
  );

  u8u16_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
